// ----- hdl/hash_table_key_value_store_unit_defines.svh -----
// Assertion helpers shared by the hash table modules.
`ifndef HASH_TABLE_KEY_VALUE_STORE_UNIT_DEFINES_SVH
`define HASH_TABLE_KEY_VALUE_STORE_UNIT_DEFINES_SVH
// Clocked property check, disabled while reset is asserted.
`define HT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Clocked check that a condition never holds, disabled while reset is asserted.
`define HT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`endif

// ----- hdl/htkv_pkg.sv -----
// ----------------------------------------------------------------------------
// htkv_pkg
// Shared types and constants for the hash table key/value store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package htkv_pkg;
  localparam int unsigned MaxBucketsDef = 256;
  localparam int unsigned WaysDef       = 4;
  localparam int unsigned KeyBitsDef    = 32;
  localparam int unsigned DataBitsDef   = 32;
  localparam int unsigned CntW          = 11;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_GET    = 2'd2;
  localparam logic [1:0] KIND_FIND   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] data_out;
    logic [10:0] entries;
  } rsp_t;
endpackage

// ----- hdl/htkv_front.sv -----
// ----------------------------------------------------------------------------
// htkv_front
// Accepts requests, computes the bucket index (key mod bucket count)
// bit-serially by restoring subtraction, and pushes a classified command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module htkv_front #(
  parameter int unsigned MAX_BUCKETS = htkv_pkg::MaxBucketsDef,
  parameter int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  htkv_pkg::req_t req_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [8:0]     bucket_count_i,
  output htkv_pkg::req_t cmd_o,
  output logic [BW-1:0]  cmd_bucket_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);
  import htkv_pkg::*;
  `include "hash_table_key_value_store_unit_defines.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;
  localparam int unsigned DW = 13; // divisor width covers 4096

  logic [1:0]  st_q, st_d;
  req_t        req_q;
  logic [31:0] quo_q, quo_d;  // dividend bits shifted out MSB first
  logic [DW-1:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [DW-1:0] div_q;
  logic [DW:0] trial;
  logic [12:0] bc_eff;

  always_comb begin
    bc_eff = {4'd0, bucket_count_i};
    if (bc_eff == 13'd0) bc_eff = 13'd1;
    if (bc_eff > 13'(MAX_BUCKETS)) bc_eff = 13'(MAX_BUCKETS);
  end

  assign ready_o = (st_q == ST_IDLE);
  assign trial   = {rem_q, quo_q[31]} - {1'b0, div_q};

  always_comb begin
    st_d = st_q; quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q;
    case (st_q)
      ST_IDLE: begin
        if (valid_i) begin
          st_d = ST_DIV; quo_d = req_i.key; rem_d = '0; cnt_d = '0;
        end
      end
      ST_DIV: begin
        // one bit per cycle; divisor below 2^13 so remainder fits DW bits
        quo_d = {quo_q[30:0], 1'b0};
        if (!trial[DW]) rem_d = trial[DW-1:0];
        else            rem_d = {rem_q[DW-2:0], quo_q[31]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) st_d = ST_PUSH;
      end
      ST_PUSH: if (cmd_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; cnt_q <= cnt_d;
    if (ready_o && valid_i) begin
      req_q <= req_i; div_q <= bc_eff;
    end
  end

  assign cmd_valid_o  = (st_q == ST_PUSH);
  assign cmd_o        = req_q;
  assign cmd_bucket_o = BW'(rem_q);

  `HT_ASSERT(a_rem_lt_div, clk_i, rst_ni, cmd_valid_o |-> (rem_q < div_q), "bad remainder")
  `HT_ASSERT(a_push_hold, clk_i, rst_ni, (cmd_valid_o && !cmd_ready_i) |=> cmd_valid_o, "push dropped")
  `HT_ASSERT(a_no_accept_busy, clk_i, rst_ni, (st_q != ST_IDLE) |-> !ready_o, "accept while busy")
endmodule

// ----- hdl/htkv_fifo.sv -----
// ----------------------------------------------------------------------------
// htkv_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module htkv_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] wdata_i,
  input  logic         wvalid_i,
  output logic         wready_o,
  output logic [W-1:0] rdata_o,
  output logic         rvalid_o,
  input  logic         rready_i
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign wready_o = (cnt_q != 2'd2);
  assign rvalid_o = (cnt_q != 2'd0);
  assign rdata_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wvalid_i && wready_o) wp_q <= ~wp_q;
      if (rvalid_o && rready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'((wvalid_i && wready_o)) - 2'((rvalid_o && rready_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wvalid_i && wready_o) mem_q[wp_q] <= wdata_i;
  end
endmodule

// ----- hdl/htkv_back.sv -----
// ----------------------------------------------------------------------------
// htkv_back
// Executes commands against the slot memory: probes bucket ways one at a
// time, or sweeps the slots in order for find; holds the result register.
// Valid bits are cleared by a pass over every slot after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module htkv_back #(
  parameter int unsigned MAX_BUCKETS = htkv_pkg::MaxBucketsDef,
  parameter int unsigned WAYS        = htkv_pkg::WaysDef,
  parameter int unsigned KEY_BITS    = htkv_pkg::KeyBitsDef,
  parameter int unsigned DATA_BITS   = htkv_pkg::DataBitsDef,
  parameter int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  htkv_pkg::req_t cmd_i,
  input  logic [BW-1:0]  cmd_bucket_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  output htkv_pkg::rsp_t rsp_o,
  output logic           valid_o,
  input  logic           ready_i
);
  import htkv_pkg::*;
  `include "hash_table_key_value_store_unit_defines.svh"

  localparam int unsigned SLOTS = MAX_BUCKETS * WAYS;
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int unsigned VW = (DATA_BITS < 32) ? DATA_BITS : 32;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1; // address issued, data next cycle
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5; // one slot per cycle after reset

  logic [KW-1:0] key_mem [SLOTS];
  logic [VW-1:0] dat_mem [SLOTS];
  logic          vld_q [SLOTS];

  logic [2:0]    st_q, st_d;
  req_t          cmd_q;
  logic [SW-1:0] addr_q, addr_d;
  logic [SW-1:0] clr_q;
  logic [WW:0]   way_q, way_d;
  logic          free_ok_q, free_ok_d;
  logic [SW-1:0] free_q, free_d;
  logic [KW-1:0] rkey_q;
  logic [VW-1:0] rdat_q;
  logic          rvld_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  rsp_t          rsp_q, rsp_d;
  logic          last;
  logic          do_wr, wr_vld;
  logic [SW-1:0] wr_addr;
  logic [KW-1:0] ckey;
  logic [VW-1:0] cval;

  assign ckey = cmd_q.key[KW-1:0];
  assign cval = cmd_q.value[VW-1:0];
  assign cmd_ready_o = (st_q == ST_IDLE);
  assign valid_o = (st_q == ST_OUT);
  assign rsp_o = rsp_q;
  assign last = (cmd_q.kind == KIND_FIND) ? (addr_q == SW'(SLOTS - 1))
                                          : (way_q == (WW+1)'(WAYS - 1));

  always_comb begin
    st_d = st_q; addr_d = addr_q; way_d = way_q; free_ok_d = free_ok_q;
    free_d = free_q; cnt_d = cnt_q; rsp_d = rsp_q;
    do_wr = 1'b0; wr_vld = 1'b0; wr_addr = addr_q;
    case (st_q)
      ST_CLEAR: begin
        do_wr = 1'b1; wr_vld = 1'b0; wr_addr = clr_q;
        if (clr_q == SW'(SLOTS - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          st_d = ST_READ; way_d = '0; free_ok_d = 1'b0;
          rsp_d = '0;
          addr_d = (cmd_i.kind == KIND_FIND) ? '0
                   : SW'(SW'(cmd_bucket_i) * SW'(WAYS));
        end
      end
      ST_READ: st_d = ST_CHECK;
      ST_CHECK: begin
        st_d = ST_READ;
        addr_d = addr_q + SW'(1);
        way_d = way_q + (WW+1)'(1);
        if (cmd_q.kind == KIND_FIND) begin
          if (rvld_q && rdat_q == cval) begin
            rsp_d.hit = 1'b1; rsp_d.data_out = 32'(rdat_q); st_d = ST_OUT;
          end else if (last) st_d = ST_OUT;
        end else if (rvld_q && rkey_q == ckey) begin
          if (cmd_q.kind == KIND_INSERT) begin
            st_d = ST_OUT;
          end else begin
            rsp_d.hit = 1'b1; rsp_d.data_out = 32'(rdat_q); st_d = ST_OUT;
            if (cmd_q.kind == KIND_REMOVE) begin
              do_wr = 1'b1; wr_vld = 1'b0; wr_addr = addr_q;
              if (cnt_q != '0) cnt_d = cnt_q - CntW'(1);
            end
          end
        end else begin
          if (!rvld_q && !free_ok_q) begin
            free_ok_d = 1'b1; free_d = addr_q;
          end
          if (last) begin
            if (cmd_q.kind == KIND_INSERT && (free_ok_q || !rvld_q)) begin
              st_d = ST_WRITE;
            end else st_d = ST_OUT;
          end
        end
      end
      ST_WRITE: begin
        do_wr = 1'b1; wr_vld = 1'b1; wr_addr = free_q;
        rsp_d.hit = 1'b1; cnt_d = cnt_q + CntW'(1); st_d = ST_OUT;
      end
      ST_OUT: if (ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
    rsp_d.entries = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; cnt_q <= '0; clr_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d;
      if (st_q == ST_CLEAR) clr_q <= clr_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    addr_q <= addr_d; way_q <= way_d; free_ok_q <= free_ok_d; free_q <= free_d;
    rsp_q <= rsp_d;
    rkey_q <= key_mem[addr_q];
    rdat_q <= dat_mem[addr_q];
    rvld_q <= vld_q[addr_q];
    if (do_wr) vld_q[wr_addr] <= wr_vld;
    if (do_wr && wr_vld) begin
      key_mem[wr_addr] <= ckey;
      dat_mem[wr_addr] <= cval;
    end
  end

  `HT_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= CntW'(SLOTS), "count overflow")
  `HT_ASSERT(a_wr_hit, clk_i, rst_ni, (st_q == ST_WRITE) |=> (valid_o && rsp_q.hit), "insert lost")
  `HT_ASSERT(a_miss_zero, clk_i, rst_ni, (valid_o && !rsp_q.hit) |-> (rsp_q.data_out == 32'd0), "miss data")
  `HT_NEVER(a_clear_quiet, clk_i, rst_ni, (st_q == ST_CLEAR) && (cmd_ready_o || valid_o), "busy during clear")
endmodule

// ----- hdl/hash_table_key_value_store_unit.sv -----
// ----------------------------------------------------------------------------
// hash_table_key_value_store_unit
// Set-associative key/value store with insert, remove, get and find.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on req_i/valid_i/ready_o; one result per item leaves on
//    rsp_o/valid_o/ready_i. Both sides are valid/ready.
//  - bucket_count is written by cfg_we_i/cfg_wdata_i; the user must do this
//    only while the unit is idle, as the block itself does not enforce it.
//  - The front computes key mod bucket count one bit per cycle, then queues
//    the command in a two-entry queue; it takes no new item until it is queued.
//  - The back probes the bucket ways one at a time through a registered slot
//    memory read (a read state, then a check state per way), plus a write
//    state for a stored insert.
//  - The serial modulo loop sets the pace of key requests. Find sweeps the
//    slots in order until a value matches or the last slot is checked.
//  - Reset clears the entry count and queue at once, bucket count returns to
//    256, and the back clears the valid bits in a pass over every slot
//    before it takes its first command.
//  - A stalled receiver holds the result; the queue then fills and ready_o
//    drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module hash_table_key_value_store_unit #(
  parameter int unsigned MAX_BUCKETS = htkv_pkg::MaxBucketsDef,
  parameter int unsigned WAYS        = htkv_pkg::WaysDef,
  parameter int unsigned KEY_BITS    = htkv_pkg::KeyBitsDef,
  parameter int unsigned DATA_BITS   = htkv_pkg::DataBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  htkv_pkg::req_t req_i,
  input  logic           valid_i,
  output logic           ready_o,
  output htkv_pkg::rsp_t rsp_o,
  output logic           valid_o,
  input  logic           ready_i,
  input  logic           cfg_we_i,
  input  logic [8:0]     cfg_wdata_i
);
  import htkv_pkg::*;

  localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned QW = $bits(req_t) + BW;

  logic [8:0]    bucket_count_q;
  req_t          f_cmd, b_cmd;
  logic [BW-1:0] f_bkt, b_bkt;
  logic          f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0] q_rd;

  // configuration register, reset to 256 buckets (the full table at the default MAX_BUCKETS)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= 9'd256;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  htkv_front #(.MAX_BUCKETS(MAX_BUCKETS), .BW(BW)) u_front (
    .clk_i, .rst_ni, .req_i, .valid_i, .ready_o,
    .bucket_count_i(bucket_count_q),
    .cmd_o(f_cmd), .cmd_bucket_o(f_bkt), .cmd_valid_o(f_valid), .cmd_ready_i(f_ready)
  );

  htkv_fifo #(.W(QW)) u_fifo (
    .clk_i, .rst_ni,
    .wdata_i({f_cmd, f_bkt}), .wvalid_i(f_valid), .wready_o(f_ready),
    .rdata_o(q_rd), .rvalid_o(b_valid), .rready_i(b_ready)
  );

  assign b_cmd = q_rd[QW-1:BW];
  assign b_bkt = q_rd[BW-1:0];

  htkv_back #(
    .MAX_BUCKETS(MAX_BUCKETS), .WAYS(WAYS), .KEY_BITS(KEY_BITS),
    .DATA_BITS(DATA_BITS), .BW(BW)
  ) u_back (
    .clk_i, .rst_ni,
    .cmd_i(b_cmd), .cmd_bucket_i(b_bkt), .cmd_valid_i(b_valid), .cmd_ready_o(b_ready),
    .rsp_o, .valid_o, .ready_i
  );
endmodule
